/* sv/qmj_pkg.sv */
// ----------------------------------------------------------------------------
// qmj_pkg
// Shared widths and the item type passed from the front end to the back end.
// ----------------------------------------------------------------------------
package qmj_pkg;

  localparam int IW       = 32;  // width of each boundary-state field
  localparam int DW       = 14;  // width of the duration field
  localparam int CW       = 48;  // width of each coefficient
  localparam int FIFO_AW  = 2;   // queue address bits
  localparam int FIFO_DEP = 4;   // queue depth

  // Classified item: start state, end-state differences, nonzero duration
  typedef struct packed {
    logic signed [IW-1:0] sp;
    logic signed [IW-1:0] sv;
    logic signed [IW-1:0] sa;
    logic signed [IW:0]   dp;
    logic signed [IW:0]   dv;
    logic signed [IW:0]   da;
    logic [DW-1:0]        dur;
  } item_t;

endpackage

/* sv/qmj_front.sv */
// ----------------------------------------------------------------------------
// qmj_front
// Accepts input beats, forms end-state differences, clamps a zero duration.
// ----------------------------------------------------------------------------
module qmj_front (
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [207:0]          s_axis_tdata,
  input  logic                  full,
  output logic                  push,
  output qmj_pkg::item_t        item
);
  import qmj_pkg::*;

  logic signed [IW-1:0] sp, sv, sa, ep, ev, ea;
  logic [DW-1:0]        dur;

  assign sp  = s_axis_tdata[31:0];
  assign sv  = s_axis_tdata[63:32];
  assign sa  = s_axis_tdata[95:64];
  assign ep  = s_axis_tdata[127:96];
  assign ev  = s_axis_tdata[159:128];
  assign ea  = s_axis_tdata[191:160];
  assign dur = s_axis_tdata[205:192];

  assign s_axis_tready = !full;
  assign push          = s_axis_tvalid && !full;

  always_comb begin
    item.sp  = sp;
    item.sv  = sv;
    item.sa  = sa;
    item.dp  = (IW+1)'(ep) - (IW+1)'(sp);
    item.dv  = (IW+1)'(ev) - (IW+1)'(sv);
    item.da  = (IW+1)'(ea) - (IW+1)'(sa);
    // treat zero duration as the shortest one
    item.dur = (dur == '0) ? DW'(1) : dur;
  end

endmodule

/* sv/qmj_fifo.sv */
// ----------------------------------------------------------------------------
// qmj_fifo
// Short queue between front and back end so each side stalls on its own.
// ----------------------------------------------------------------------------
module qmj_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  qmj_pkg::item_t wr_item,
  output logic           full,
  input  logic           pop,
  output logic           rd_vld,
  output qmj_pkg::item_t rd_item
);
  import qmj_pkg::*;

  item_t              mem [FIFO_DEP];
  logic [FIFO_AW-1:0] wptr, rptr;
  logic [FIFO_AW:0]   count;
  logic               do_pop;

  assign full    = (count == (FIFO_AW+1)'(FIFO_DEP));
  assign rd_vld  = (count != '0);
  assign do_pop  = pop && rd_vld;
  assign rd_item = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (do_pop) rptr <= rptr + 1'b1;
      if (push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !push) count <= count - 1'b1;
    end
    if (push) mem[wptr] <= wr_item;
  end

endmodule

/* sv/qmj_div.sv */
// ----------------------------------------------------------------------------
// qmj_div
// Pipelined restoring divider: round(mag * 2^SH / den), one quotient bit per
// stage, rounded half away from zero and clipped to a signed coefficient.
// ----------------------------------------------------------------------------
module qmj_div #(
  parameter int MW    = 80,
  parameter int DENIW = 42,
  parameter int SH    = 17,
  parameter int TW    = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   vld_in,
  input  logic [MW-1:0]          mag,
  input  logic                   neg,
  input  logic [DENIW-1:0]       den,
  input  logic [TW-1:0]          tag_in,
  output logic                   vld_out,
  output logic [qmj_pkg::CW-1:0] coef,
  output logic                   sat,
  output logic [TW-1:0]          tag_out
);
  import qmj_pkg::*;

  localparam int NSH  = (SH > 0) ? SH : 0;
  localparam int DSH  = (SH < 0) ? -SH : 0;
  localparam int NW   = MW + NSH;
  localparam int DENW = DENIW + DSH;
  localparam int HW   = NW - CW;
  localparam int CMPW = ((HW > DENW) ? HW : DENW) + 1;

  logic [NW-1:0]   num_full;
  logic [DENW-1:0] den_full;
  logic            ovf0;

  logic [DENW-1:0] rem [0:CW];
  logic [CW-1:0]   low [0:CW-1];
  logic [CW-1:0]   quo [0:CW];
  logic [DENW-1:0] dn  [0:CW];
  logic            ng  [0:CW];
  logic            ov  [0:CW];
  logic            vl  [0:CW];
  logic [TW-1:0]   tg  [0:CW];

  assign num_full = NW'(mag) << NSH;
  assign den_full = DENW'(den) << DSH;
  // quotient would need more than CW bits
  assign ovf0 = CMPW'(num_full[NW-1:CW]) >= CMPW'(den_full);

  always_ff @(posedge clk) begin
    if (rst) vl[0] <= 1'b0;
    else if (en) vl[0] <= vld_in;
    if (en) begin
      rem[0] <= ovf0 ? '0 : DENW'(num_full[NW-1:CW]);
      low[0] <= num_full[CW-1:0];
      quo[0] <= '0;
      dn[0]  <= den_full;
      ng[0]  <= neg;
      ov[0]  <= ovf0;
      tg[0]  <= tag_in;
    end
  end

  for (genvar i = 1; i <= CW; i++) begin : g_step
    logic [DENW:0] cur;
    logic          ge;

    assign cur = {rem[i-1], low[i-1][CW-1]};
    assign ge  = cur >= {1'b0, dn[i-1]};

    always_ff @(posedge clk) begin
      if (rst) vl[i] <= 1'b0;
      else if (en) vl[i] <= vl[i-1];
      if (en) begin
        rem[i] <= ge ? DENW'(cur - {1'b0, dn[i-1]}) : DENW'(cur);
        quo[i] <= {quo[i-1][CW-2:0], ge};
        dn[i]  <= dn[i-1];
        ng[i]  <= ng[i-1];
        ov[i]  <= ov[i-1];
        tg[i]  <= tg[i-1];
      end
    end

    if (i < CW) begin : g_low
      always_ff @(posedge clk) begin
        if (en) low[i] <= low[i-1] << 1;
      end
    end
  end

  logic          rbit;
  logic [CW:0]   q_rnd, lim;
  logic          clip;
  logic [CW-1:0] m;

  assign rbit  = {rem[CW], 1'b0} >= {1'b0, dn[CW]};
  assign q_rnd = {1'b0, quo[CW]} + (CW+1)'(rbit);
  assign lim   = ng[CW] ? ((CW+1)'(1) << (CW-1)) : (((CW+1)'(1) << (CW-1)) - 1'b1);
  assign clip  = ov[CW] || (q_rnd > lim);
  assign m     = clip ? lim[CW-1:0] : q_rnd[CW-1:0];

  always_ff @(posedge clk) begin
    if (rst) vld_out <= 1'b0;
    else if (en) vld_out <= vl[CW];
    if (en) begin
      coef    <= ng[CW] ? (CW)'(-m) : m;
      sat     <= clip;
      tag_out <= tg[CW];
    end
  end

endmodule

/* sv/qmj_back.sv */
// ----------------------------------------------------------------------------
// qmj_back
// Arithmetic pipeline: residual numerators, duration powers, then three
// pipelined dividers for the cubic, quartic and quintic terms.
// ----------------------------------------------------------------------------
module qmj_back #(
  parameter int IN_FRAC_BITS       = 16,
  parameter int OUT_FRAC_BITS      = 24,
  parameter int DURATION_FRAC_BITS = 10
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           rd_vld,
  input  qmj_pkg::item_t rd_item,
  output logic           pop,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [287:0]   m_axis_tdata,
  output logic           m_axis_tuser
);
  import qmj_pkg::*;

  localparam int DQ   = DURATION_FRAC_BITS;
  localparam int EB   = OUT_FRAC_BITS - IN_FRAC_BITS;
  localparam int MPW  = IW + DW + 1;
  localparam int P1W  = (((IW+1+DQ) > MPW) ? (IW+1+DQ) : MPW) + 1;
  localparam int PAW  = (((IW+2+2*DQ) > (MPW+DQ+1)) ? (IW+2+2*DQ) : (MPW+DQ+1)) + 1;
  localparam int SDW  = MPW + DW + 1;
  localparam int P0W  = ((PAW > SDW) ? PAW : SDW) + 1;
  localparam int R1W  = P1W + DW + 1;
  localparam int R2W  = IW + 1 + 2*DW + 1;
  localparam int QM   = (P0W > R1W) ? P0W : R1W;
  localparam int QW   = ((QM > R2W) ? QM : R2W) + 5;
  localparam int TW   = 3*CW + 1;

  logic en;
  logic m_sat3, m_sat4, m_sat5;
  logic [CW-1:0] c3, c4, c5;
  logic [TW-1:0] tag_o;

  // advance unless the output beat is held
  assign en  = !(m_axis_tvalid && !m_axis_tready);
  assign pop = en;

  function automatic logic [CW:0] fix_in(input logic signed [IW-1:0] v, input int s);
    logic signed [63:0] t;
    logic [63:0]        mg;
    logic               st;
    logic [CW-1:0]      r;
    t  = 64'(v);
    st = 1'b0;
    if (s >= 0) begin
      t  = t <<< s;
      st = (t > 64'sd140737488355327) || (t < -64'sd140737488355328);
      if (st) r = t[63] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      else r = t[CW-1:0];
    end else begin
      mg = t[63] ? 64'(-t) : 64'(t);
      mg = (mg + (64'd1 << (-s - 1))) >> (-s);
      r  = t[63] ? CW'(-mg) : mg[CW-1:0];
    end
    return {st, r};
  endfunction

  // stage 0: registered item
  logic          v0;
  item_t         s0;
  // stage 1
  logic              v1;
  logic signed [IW:0] s1_dp, s1_dv, s1_da;
  logic signed [MPW-1:0] s1_m1, s1_m2;
  logic [2*DW-1:0]   s1_d2;
  logic [DW-1:0]     s1_d;
  logic [TW-1:0]     s1_tag;
  // stage 2
  logic              v2;
  logic signed [SDW-1:0] s2_sad2;
  logic signed [P1W-1:0] s2_p1;
  logic signed [PAW-1:0] s2_p0a;
  logic signed [IW:0]    s2_da;
  logic [2*DW-1:0]   s2_d2;
  logic [3*DW-1:0]   s2_d3;
  logic [DW-1:0]     s2_d;
  logic [TW-1:0]     s2_tag;
  // stage 3
  logic              v3;
  logic signed [P0W-1:0] s3_p0;
  logic signed [R1W-1:0] s3_r1;
  logic signed [R2W-1:0] s3_r2;
  logic [3*DW-1:0]   s3_d3;
  logic [4*DW-1:0]   s3_d4;
  logic [DW-1:0]     s3_d;
  logic [TW-1:0]     s3_tag;
  // stage 4
  logic              v4;
  logic signed [QW-1:0] s4_q3, s4_q4, s4_q5;
  logic [3*DW-1:0]   s4_d3;
  logic [4*DW-1:0]   s4_d4;
  logic [5*DW-1:0]   s4_d5;
  logic [TW-1:0]     s4_tag;
  // stage 5
  logic              v5;
  logic [QW-1:0]     s5_m3, s5_m4, s5_m5;
  logic              s5_n3, s5_n4, s5_n5;
  logic [3*DW-1:0]   s5_d3;
  logic [4*DW-1:0]   s5_d4;
  logic [5*DW-1:0]   s5_d5;
  logic [TW-1:0]     s5_tag;

  logic [CW:0] f0, f1, f2;
  assign f0 = fix_in(s0.sp, EB);
  assign f1 = fix_in(s0.sv, EB);
  assign f2 = fix_in(s0.sa, EB - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0; v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
    end else if (en) begin
      v0 <= rd_vld; v1 <= v0; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
    end
    if (en) begin
      s0 <= rd_item;

      s1_dp  <= s0.dp;
      s1_dv  <= s0.dv;
      s1_da  <= s0.da;
      s1_m1  <= s0.sv * $signed({1'b0, s0.dur});
      s1_m2  <= s0.sa * $signed({1'b0, s0.dur});
      s1_d2  <= s0.dur * s0.dur;
      s1_d   <= s0.dur;
      s1_tag <= {f0[CW] | f1[CW] | f2[CW], f2[CW-1:0], f1[CW-1:0], f0[CW-1:0]};

      s2_sad2 <= s1_m2 * $signed({1'b0, s1_d});
      s2_p1   <= (P1W'(s1_dv) <<< DQ) - P1W'(s1_m2);
      s2_p0a  <= (PAW'(s1_dp) <<< (2*DQ + 1)) - (PAW'(s1_m1) <<< (DQ + 1));
      s2_da   <= s1_da;
      s2_d2   <= s1_d2;
      s2_d3   <= s1_d2 * s1_d;
      s2_d    <= s1_d;
      s2_tag  <= s1_tag;

      s3_p0  <= P0W'(s2_p0a) - P0W'(s2_sad2);
      s3_r1  <= s2_p1 * $signed({1'b0, s2_d});
      s3_r2  <= s2_da * $signed({1'b0, s2_d2});
      s3_d3  <= s2_d3;
      s3_d4  <= s2_d3 * s2_d;
      s3_d   <= s2_d;
      s3_tag <= s2_tag;

      s4_q3  <= QW'(s3_p0) * 10 - (QW'(s3_r1) <<< 3) + QW'(s3_r2);
      s4_q4  <= QW'(s3_r1) * 14 - QW'(s3_p0) * 15 - (QW'(s3_r2) <<< 1);
      s4_q5  <= QW'(s3_p0) * 6 - QW'(s3_r1) * 6 + QW'(s3_r2);
      s4_d3  <= s3_d3;
      s4_d4  <= s3_d4;
      s4_d5  <= s3_d4 * s3_d;
      s4_tag <= s3_tag;

      s5_n3  <= s4_q3[QW-1];
      s5_n4  <= s4_q4[QW-1];
      s5_n5  <= s4_q5[QW-1];
      s5_m3  <= s4_q3[QW-1] ? QW'(-s4_q3) : QW'(s4_q3);
      s5_m4  <= s4_q4[QW-1] ? QW'(-s4_q4) : QW'(s4_q4);
      s5_m5  <= s4_q5[QW-1] ? QW'(-s4_q5) : QW'(s4_q5);
      s5_d3  <= s4_d3;
      s5_d4  <= s4_d4;
      s5_d5  <= s4_d5;
      s5_tag <= s4_tag;
    end
  end

  qmj_div #(.MW(QW), .DENIW(3*DW), .SH(DQ + EB - 1), .TW(TW)) u_div3 (
    .clk(clk), .rst(rst), .en(en), .vld_in(v5), .mag(s5_m3), .neg(s5_n3),
    .den(s5_d3), .tag_in(s5_tag), .vld_out(m_axis_tvalid), .coef(c3),
    .sat(m_sat3), .tag_out(tag_o)
  );

  qmj_div #(.MW(QW), .DENIW(4*DW), .SH(2*DQ + EB - 1), .TW(1)) u_div4 (
    .clk(clk), .rst(rst), .en(en), .vld_in(v5), .mag(s5_m4), .neg(s5_n4),
    .den(s5_d4), .tag_in(1'b0), .vld_out(), .coef(c4), .sat(m_sat4),
    .tag_out()
  );

  qmj_div #(.MW(QW), .DENIW(5*DW), .SH(3*DQ + EB - 1), .TW(1)) u_div5 (
    .clk(clk), .rst(rst), .en(en), .vld_in(v5), .mag(s5_m5), .neg(s5_n5),
    .den(s5_d5), .tag_in(1'b0), .vld_out(), .coef(c5), .sat(m_sat5),
    .tag_out()
  );

  assign m_axis_tdata = {c5, c4, c3, tag_o[3*CW-1:0]};
  assign m_axis_tuser = tag_o[3*CW] | m_sat3 | m_sat4 | m_sat5;

endmodule

/* sv/quintic_min_jerk_coefficients.sv */
// ----------------------------------------------------------------------------
// quintic_min_jerk_coefficients
// Minimum-jerk quintic coefficients for one axis from boundary states.
// ----------------------------------------------------------------------------
// Takes one item per cycle when nothing stalls and delivers one result beat
// per item, in order. An accepted input beat is written to the input queue
// at the accept edge, then passes six arithmetic stages, then a 50-register
// restoring divider (a load stage, 48 stages of one quotient bit each and an
// output register) for each of the cubic, quartic and quintic terms, which
// run side by side; the divider output register raises m_axis_tvalid. A held
// output beat stalls the pipeline; the four-entry input queue keeps
// accepting until it fills. Coefficients are rounded to nearest with ties
// away from zero and clipped to 48 bits, with tuser set when any coefficient
// clipped.
module quintic_min_jerk_coefficients #(
  parameter int IN_FRAC_BITS       = 16,
  parameter int OUT_FRAC_BITS      = 24,
  parameter int DURATION_FRAC_BITS = 10
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // start_position, start_velocity, start_accel, end_position, end_velocity,
  // end_accel (32 each), duration (14), zero pad
  input  logic [207:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // coef0, coef1, coef2, coef3, coef4, coef5 (48 each)
  output logic [287:0] m_axis_tdata,
  // saturated
  output logic         m_axis_tuser
);
  import qmj_pkg::*;

  logic  push, full, pop, rd_vld;
  item_t wr_item, rd_item;

  qmj_front u_front (
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .full(full), .push(push), .item(wr_item)
  );

  qmj_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .wr_item(wr_item), .full(full),
    .pop(pop), .rd_vld(rd_vld), .rd_item(rd_item)
  );

  qmj_back #(
    .IN_FRAC_BITS(IN_FRAC_BITS), .OUT_FRAC_BITS(OUT_FRAC_BITS),
    .DURATION_FRAC_BITS(DURATION_FRAC_BITS)
  ) u_back (
    .clk(clk), .rst(rst), .rd_vld(rd_vld), .rd_item(rd_item), .pop(pop),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

endmodule

/* tb/sv/qmj_coef_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmj_coef_checker
// Watches both streams, works out the coefficients and compares each result.
// ----------------------------------------------------------------------------
module qmj_coef_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  // start_position, start_velocity, start_accel, end_position, end_velocity,
  // end_accel (32 each), duration (14), zero pad
  input  logic [207:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // coef0 .. coef5 (48 each)
  input  logic [287:0] m_axis_tdata,
  // saturated
  input  logic         m_axis_tuser,
  output int           errors,
  output int           pending,
  output int           results_seen,
  output int           sat_seen
);

  localparam int EB = 24 - 16;
  localparam int DQ = 10;

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    logic [287:0] coefs;
    logic         sat;
  } coef_set_t;

  coef_set_t expected_q[$];

  // round(num * 2^e / den) to nearest, ties away from zero, clipped to 48 bits
  function automatic logic [47:0] round_clip(input wide_t num, input int e,
                                             input wide_t den, inout logic sat);
    logic         neg;
    logic [255:0] mag, q, r, lim;
    neg = num[255];
    mag = neg ? -num : num;
    mag = mag << e;
    q = mag / den;
    r = mag % den;
    if ((r << 1) >= den) q = q + 1;
    lim = neg ? 256'h8000_0000_0000 : 256'h7FFF_FFFF_FFFF;
    if (q > lim) begin
      q = lim;
      sat = 1'b1;
    end
    return neg ? 48'(-q) : q[47:0];
  endfunction

  function automatic coef_set_t min_jerk_coefs(input logic [207:0] d);
    wide_t     sp, sv, sa, ep, ev, ea, t, p0, p1, p2, r1, r2, q3, q4, q5;
    coef_set_t res;
    logic      sat;
    sp = wide_t'($signed(d[31:0]));
    sv = wide_t'($signed(d[63:32]));
    sa = wide_t'($signed(d[95:64]));
    ep = wide_t'($signed(d[127:96]));
    ev = wide_t'($signed(d[159:128]));
    ea = wide_t'($signed(d[191:160]));
    t  = wide_t'({1'b0, d[205:192]});
    if (t == 0) t = 1;  // zero duration counts as the shortest one
    sat = 1'b0;
    p0 = ((ep - sp) <<< (2 * DQ + 1)) - ((sv * t) <<< (DQ + 1)) - sa * t * t;
    p1 = ((ev - sv) <<< DQ) - sa * t;
    p2 = ea - sa;
    r1 = p1 * t;
    r2 = p2 * t * t;
    q3 = 10 * p0 - 8 * r1 + r2;
    q4 = -15 * p0 + 14 * r1 - 2 * r2;
    q5 = 6 * p0 - 6 * r1 + r2;
    res.coefs[47:0]    = round_clip(sp, EB, 1, sat);
    res.coefs[95:48]   = round_clip(sv, EB, 1, sat);
    res.coefs[143:96]  = round_clip(sa, EB - 1, 1, sat);
    res.coefs[191:144] = round_clip(q3, DQ + EB - 1, t * t * t, sat);
    res.coefs[239:192] = round_clip(q4, 2 * DQ + EB - 1, t * t * t * t, sat);
    res.coefs[287:240] = round_clip(q5, 3 * DQ + EB - 1, t * t * t * t * t, sat);
    res.sat = sat;
    return res;
  endfunction

  task automatic report(input string what, input logic [63:0] got,
                        input logic [63:0] want);
    $display("MISMATCH result %0d %s: got %h want %h", results_seen, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    coef_set_t want;
    if (rst) begin
      errors = 0;
      results_seen = 0;
      sat_seen = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_q = {expected_q, min_jerk_coefs(s_axis_tdata)};
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          report("unexpected beat", 64'd0, 64'd0);
        end else begin
          want = expected_q.pop_front();
          for (int k = 0; k < 6; k++)
            if (m_axis_tdata[k*48 +: 48] !== want.coefs[k*48 +: 48])
              report($sformatf("coef%0d", k), 64'(m_axis_tdata[k*48 +: 48]),
                     64'(want.coefs[k*48 +: 48]));
          if (m_axis_tuser !== want.sat)
            report("saturated", 64'(m_axis_tuser), 64'(want.sat));
          if (want.sat) sat_seen++;
        end
        results_seen++;
      end
    end
    pending = expected_q.size();
  end

endmodule

/* tb/sv/tb_quintic_min_jerk_coefficients.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quintic_min_jerk_coefficients
// Drives boundary states and durations into the coefficient block.
// ----------------------------------------------------------------------------
// Directed extremes first, then random items mixing full-range fields with
// moderate ones that stay in range, under random idling on both sides, one
// quiet stretch and one long output hold-off. A checker compares every beat.
module tb_quintic_min_jerk_coefficients;

  localparam int RANDOM_ITEMS = 1900;
  localparam int CYCLE_LIMIT  = 400000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [207:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [287:0] m_axis_tdata;
  logic         m_axis_tuser;

  int  errors, pending, results_seen, sat_seen;
  int  items_sent = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;
  bit  hold = 1'b0;

  always #4 clk = ~clk;

  quintic_min_jerk_coefficients i_dut (.*);

  qmj_coef_checker i_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk)
    m_axis_tready <= !rst && !hold && (quiet || $urandom_range(99) >= 20);

  // long hold-off on the output so the input queue fills and stalls
  initial begin
    wait (items_sent >= 300);
    @(posedge clk);
    hold <= 1'b1;
    repeat (400) @(posedge clk);
    hold <= 1'b0;
  end

  function automatic logic [31:0] pick_field(input int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(131071)) - 65536);
      default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  task automatic send_beat(input logic [191:0] fields, input logic [13:0] dur);
    bit hit;
    if (!quiet) begin
      while ($urandom_range(99) < 20) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, dur, fields};
    do begin
      @(negedge clk);
      hit = s_axis_tready;
      @(posedge clk);
    end while (!hit);
    items_sent++;
  endtask

  initial begin
    logic [191:0] f;
    logic [13:0]  dur;
    int           mode;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_beat('0, 14'd1);
    send_beat('0, 14'd16383);
    send_beat('0, 14'd0);
    send_beat({6{32'h7FFF_FFFF}}, 14'd1);
    send_beat({6{32'h8000_0000}}, 14'd1);
    send_beat({6{32'h7FFF_FFFF}}, 14'd16383);
    send_beat({6{32'h8000_0000}}, 14'd16383);
    send_beat({{3{32'h7FFF_FFFF}}, {3{32'h8000_0000}}}, 14'd1);
    send_beat({{3{32'h8000_0000}}, {3{32'h7FFF_FFFF}}}, 14'd16383);
    send_beat({6{32'hFFFF_FFFF}}, 14'd1024);
    send_beat({6{32'h0000_0001}}, 14'd3);
    send_beat({32'd0, 32'd0, 32'h0001_0000, 32'd0, 32'd0, 32'd0}, 14'd1024);
    send_beat({32'd0, 32'd0, 32'd0, 32'h0001_0000, 32'd0, 32'd0}, 14'd2048);
    send_beat({32'd0, 32'hFFFF_0000, 32'd0, 32'd0, 32'h0002_0000, 32'd0}, 14'd512);
    send_beat({32'h0000_8000, 32'd0, 32'd0, 32'd0, 32'd0, 32'h0000_0003}, 14'd7);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= 600 && n < 900);
      mode = $urandom_range(9);
      for (int k = 0; k < 6; k++)
        f[k*32 +: 32] = pick_field(mode < 3 ? 0 : (mode < 9 ? 1 : 2));
      case ($urandom_range(3))
        0: dur = 14'($urandom_range(16383));
        1: dur = 14'($urandom_range(64) + 1);
        2: dur = 14'($urandom_range(4096) + 256);
        default: dur = $urandom_range(1) ? 14'd16383 : 14'd1;
      endcase
      send_beat(f, dur);
    end
    quiet = 1'b0;
    s_axis_tvalid <= 1'b0;

    @(posedge clk);
    wait (pending == 0);
    repeat (200) @(posedge clk);
    $display("sent %0d items, checked %0d results, %0d of them saturated",
             items_sent, results_seen, sat_seen);
    if (errors == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
